>>> sv/jwam_pkg.sv
package jwam_pkg;

  localparam logic [7:0] CENTRE      = 8'd64;
  localparam logic [7:0] TPT_MAX     = 8'd128;
  localparam int         CMD_Q_DEPTH = 4;
  localparam int         CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

  localparam logic OP_JOG  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_MOUSE_X = 3'd1;
  localparam logic [2:0] MODE_MOUSE_Y = 3'd2;
  localparam logic [2:0] MODE_HELD    = 3'd3;
  localparam logic [2:0] MODE_TAP     = 3'd4;

  localparam logic [2:0] CFG_JOG_MODE     = 3'd0;
  localparam logic [2:0] CFG_DEAD_ZONE    = 3'd1;
  localparam logic [2:0] CFG_MOUSE_GAIN   = 3'd2;
  localparam logic [2:0] CFG_PRESS_LEVEL  = 3'd3;
  localparam logic [2:0] CFG_TAP_STEP     = 3'd4;
  localparam logic [2:0] CFG_HOLD_TIMEOUT = 3'd5;
  localparam logic [2:0] CFG_HOLD_KEYS    = 3'd6;
  localparam logic [2:0] CFG_TAP_KEYS     = 3'd7;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TAP     = 2'd2,
    ACT_MOVE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_KEYS    = 2'd0,
    CMD_MOVE_X  = 2'd1,
    CMD_MOVE_Y  = 2'd2,
    CMD_TAP     = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_KEY0,
    BS_KEY1,
    BS_MOVE,
    BS_TAP
  } bstate_t;

  typedef struct packed {
    logic [2:0]  jog_mode;
    logic [6:0]  dead_zone;
    logic [7:0]  mouse_gain;
    logic [6:0]  press_level;
    logic [7:0]  tap_step;
    logic [15:0] hold_timeout;
    logic [15:0] hold_keys;
    logic [15:0] tap_keys;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    action_t            act0;
    logic [7:0]         key0;
    action_t            act1;
    logic [7:0]         key1;
    logic               two;
    logic signed [14:0] move;
    logic signed [7:0]  delta;
  } cmd_t;

endpackage

>>> sv/jwam_cmd_q.sv
module jwam_cmd_q
  import jwam_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t                mem_r [CMD_Q_DEPTH];
  logic [CMD_Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_Q_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/jwam_front.sv
module jwam_front
  import jwam_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_push,
  input  logic       in_opcode,
  input  logic [6:0] in_jog_value,
  output logic       in_full,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [TIMER_WIDTH-1:0] idle_r, idle_nxt, idle_inc;
  logic                   left_held_r, left_held_nxt;
  logic                   right_held_r, right_held_nxt;

  logic               accept;
  logic signed [7:0]  delta;
  logic [7:0]         mag;
  logic               ignored;
  logic signed [8:0]  d9, thr9;
  logic               pos, neg, timed_out;
  logic signed [16:0] prod;
  logic               a_v, b_v;
  action_t            a_act, b_act;
  logic [7:0]         a_key, b_key, left_key, right_key;
  logic               keys_cmd;

  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign left_key  = cfg.hold_keys[7:0];
  assign right_key = cfg.hold_keys[15:8];

  always_comb begin
    delta     = $signed({1'b0, in_jog_value} - CENTRE);
    mag       = delta[7] ? 8'(-delta) : 8'(delta);
    ignored   = (mag <= {1'b0, cfg.dead_zone});
    d9        = {delta[7], delta};
    thr9      = $signed({2'b00, cfg.press_level});
    pos       = (d9 >= thr9);
    neg       = (d9 <= -thr9);
    prod      = delta * $signed({1'b0, cfg.mouse_gain});
    idle_inc  = (idle_r == '1) ? idle_r : idle_r + 1'b1;
    timed_out = (CW'(idle_inc) >= CW'(cfg.hold_timeout));

    idle_nxt       = idle_r;
    left_held_nxt  = left_held_r;
    right_held_nxt = right_held_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_act    = ACT_RELEASE;
    b_act    = ACT_RELEASE;
    a_key    = left_key;
    b_key    = right_key;
    keys_cmd = 1'b0;
    q_push   = 1'b0;
    q_data   = '0;

    if (accept) begin
      if (in_opcode == OP_TICK) begin
        idle_nxt = idle_inc;
        if (cfg.jog_mode == MODE_HELD && (left_held_r || right_held_r) && timed_out) begin
          keys_cmd       = 1'b1;
          a_v            = left_held_r;
          b_v            = right_held_r;
          left_held_nxt  = 1'b0;
          right_held_nxt = 1'b0;
        end
      end else if (!ignored) begin
        idle_nxt = '0;
        case (cfg.jog_mode)
          MODE_MOUSE_X: begin
            q_push      = 1'b1;
            q_data.kind = CMD_MOVE_X;
            q_data.move = prod[14:0];
          end
          MODE_MOUSE_Y: begin
            q_push      = 1'b1;
            q_data.kind = CMD_MOVE_Y;
            q_data.move = prod[14:0];
          end
          MODE_HELD: begin
            if (pos) begin
              keys_cmd       = 1'b1;
              a_v            = left_held_r;
              b_v            = !right_held_r;
              b_act          = ACT_PRESS;
              left_held_nxt  = 1'b0;
              right_held_nxt = 1'b1;
            end else if (neg) begin
              keys_cmd       = 1'b1;
              a_v            = right_held_r;
              a_key          = right_key;
              b_v            = !left_held_r;
              b_act          = ACT_PRESS;
              b_key          = left_key;
              left_held_nxt  = 1'b1;
              right_held_nxt = 1'b0;
            end
          end
          MODE_TAP: begin
            q_push       = 1'b1;
            q_data.kind  = CMD_TAP;
            q_data.delta = delta;
          end
          default: begin
          end
        endcase
      end
      if (keys_cmd && (a_v || b_v)) begin
        q_push      = 1'b1;
        q_data.kind = CMD_KEYS;
        q_data.act0 = a_v ? a_act : b_act;
        q_data.key0 = a_v ? a_key : b_key;
        q_data.act1 = b_act;
        q_data.key1 = b_key;
        q_data.two  = a_v && b_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r       <= '0;
      left_held_r  <= 1'b0;
      right_held_r <= 1'b0;
    end else begin
      idle_r       <= idle_nxt;
      left_held_r  <= left_held_nxt;
      right_held_r <= right_held_nxt;
    end
  end

endmodule

>>> sv/jwam_back.sv
module jwam_back
  import jwam_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               cfg_we,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_action,
  output logic [7:0]         out_key_code,
  output logic signed [14:0] out_move_x,
  output logic signed [14:0] out_move_y,
  output logic               out_last
);

  bstate_t            state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic signed [8:0]  residue_r, residue_nxt;
  logic               out_valid_r, out_valid_nxt;
  action_t            action_r, action_nxt;
  logic [7:0]         key_r, key_nxt;
  logic signed [14:0] mx_r, mx_nxt, my_r, my_nxt;
  logic               last_r, last_nxt;

  logic               can_emit, emit;
  logic [7:0]         tpt;
  logic signed [9:0]  tpt10, r10, r_sub, r_add;

  assign empty        = !out_valid_r;
  assign out_action   = action_r;
  assign out_key_code = key_r;
  assign out_move_x   = mx_r;
  assign out_move_y   = my_r;
  assign out_last     = last_r;
  assign can_emit     = !out_valid_r || pop;

  always_comb begin
    tpt = cfg.tap_step;
    if (tpt == '0) begin
      tpt = 8'd1;
    end else if (tpt > TPT_MAX) begin
      tpt = TPT_MAX;
    end
    tpt10 = $signed({2'b00, tpt});
    r10   = {residue_r[8], residue_r};
    r_sub = r10 - tpt10;
    r_add = r10 + tpt10;

    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    residue_nxt = residue_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    action_nxt  = action_r;
    key_nxt     = key_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    last_nxt    = last_r;

    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          case (q_data.kind)
            CMD_KEYS: state_nxt = BS_KEY0;
            CMD_TAP: begin
              state_nxt   = BS_TAP;
              residue_nxt = residue_r + {q_data.delta[7], q_data.delta};
            end
            default: state_nxt = BS_MOVE;
          endcase
        end
      end
      BS_KEY0: begin
        if (can_emit) begin
          emit       = 1'b1;
          action_nxt = cmd_r.act0;
          key_nxt    = cmd_r.key0;
          mx_nxt     = '0;
          my_nxt     = '0;
          last_nxt   = !cmd_r.two;
          state_nxt  = cmd_r.two ? BS_KEY1 : BS_IDLE;
        end
      end
      BS_KEY1: begin
        if (can_emit) begin
          emit       = 1'b1;
          action_nxt = cmd_r.act1;
          key_nxt    = cmd_r.key1;
          mx_nxt     = '0;
          my_nxt     = '0;
          last_nxt   = 1'b1;
          state_nxt  = BS_IDLE;
        end
      end
      BS_MOVE: begin
        if (can_emit) begin
          emit       = 1'b1;
          action_nxt = ACT_MOVE;
          key_nxt    = '0;
          mx_nxt     = (cmd_r.kind == CMD_MOVE_X) ? cmd_r.move : '0;
          my_nxt     = (cmd_r.kind == CMD_MOVE_Y) ? cmd_r.move : '0;
          last_nxt   = 1'b1;
          state_nxt  = BS_IDLE;
        end
      end
      BS_TAP: begin
        if (r10 >= tpt10) begin
          if (can_emit) begin
            emit        = 1'b1;
            action_nxt  = ACT_TAP;
            key_nxt     = cfg.tap_keys[15:8];
            mx_nxt      = '0;
            my_nxt      = '0;
            last_nxt    = (r_sub < tpt10);
            residue_nxt = r_sub[8:0];
            if (r_sub < tpt10) begin
              state_nxt = BS_IDLE;
            end
          end
        end else if (r10 <= -tpt10) begin
          if (can_emit) begin
            emit        = 1'b1;
            action_nxt  = ACT_TAP;
            key_nxt     = cfg.tap_keys[7:0];
            mx_nxt      = '0;
            my_nxt      = '0;
            last_nxt    = (r_add > -tpt10);
            residue_nxt = r_add[8:0];
            if (r_add > -tpt10) begin
              state_nxt = BS_IDLE;
            end
          end
        end else begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase

    if (cfg_we) begin
      residue_nxt = '0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      residue_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      residue_r   <= residue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    action_r <= action_nxt;
    key_r    <= key_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    last_r   <= last_nxt;
  end

endmodule

>>> sv/jog_wheel_action_mapper.sv
// Jog wheel action mapper.
// Input queue port: push/full with in_opcode (jog value event or 1 ms tick)
// and in_jog_value; a transfer happens when push is high and full is low.
// Result queue port: empty/pop; the oldest result sits on the out_ ports while
// empty is low and transfers when pop is high. out_last marks the final
// result of one input; inputs that cause nothing give no result at all.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while the block is idle. Any write clears the tap residue.
// The execution side fetches a command from the 4-entry command queue and
// registers its results one at a time, each only once the output register
// is free; it fetches the next command only after the last is done. A tap
// command with no tap due still passes through the tap state.
// The front side classifies an input in its transfer cycle and keeps taking
// inputs until the command queue fills.
// Reset (rst_n low, synchronous) restores register defaults and clears held
// keys, idle timer, tap residue and both queues.
// A stalled receiver holds the output register; work backs up into the
// command queue, then full rises.
module jog_wheel_action_mapper
  import jwam_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [6:0]         in_jog_value,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_action,
  output logic [7:0]         out_key_code,
  output logic signed [14:0] out_move_x,
  output logic signed [14:0] out_move_y,
  output logic               out_last
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_JOG_MODE:     cfg_nxt.jog_mode     = cfg_data[2:0];
        CFG_DEAD_ZONE:    cfg_nxt.dead_zone    = cfg_data[6:0];
        CFG_MOUSE_GAIN:   cfg_nxt.mouse_gain   = cfg_data[7:0];
        CFG_PRESS_LEVEL:  cfg_nxt.press_level  = cfg_data[6:0];
        CFG_TAP_STEP:     cfg_nxt.tap_step     = cfg_data[7:0];
        CFG_HOLD_TIMEOUT: cfg_nxt.hold_timeout = cfg_data;
        CFG_HOLD_KEYS:    cfg_nxt.hold_keys    = cfg_data;
        CFG_TAP_KEYS:     cfg_nxt.tap_keys     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jog_mode     <= MODE_NONE;
      cfg_r.dead_zone    <= 7'd0;
      cfg_r.mouse_gain   <= 8'd1;
      cfg_r.press_level  <= 7'd1;
      cfg_r.tap_step     <= 8'd1;
      cfg_r.hold_timeout <= 16'd100;
      cfg_r.hold_keys    <= 16'd0;
      cfg_r.tap_keys     <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jwam_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_push     (push),
    .in_opcode   (in_opcode),
    .in_jog_value(in_jog_value),
    .in_full     (full),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  jwam_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  jwam_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cfg_we      (cfg_we),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_action  (out_action),
    .out_key_code(out_key_code),
    .out_move_x  (out_move_x),
    .out_move_y  (out_move_y),
    .out_last    (out_last)
  );

endmodule
